// File: sv/adv_pkg.sv
// Package for the adjacency delta varint encoder: widths, byte constants and
// the coding modes that travel from the front end to the byte serialiser.
// Depends on nothing.
package adv_pkg;

    localparam int ID_WIDTH_DEFAULT = 32;

    // Depth of the queue between the classifier and the serialiser.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int HEAD_LOW_BITS = 6;
    localparam int GROUP_BITS    = 7;

    localparam logic [7:0] HEAD_SMALLER = 8'h40;
    localparam logic [7:0] HEAD_GREATER = 8'h80;
    localparam logic [7:0] ERROR_BYTE   = 8'h00;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_HEAD_LT = 2'd0;
    localparam mode_t MODE_HEAD_GE = 2'd1;
    localparam mode_t MODE_GAP     = 2'd2;
    localparam mode_t MODE_ERROR   = 2'd3;

    typedef struct packed {
        mode_t mode;
        logic  last;
    } entry_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// File: sv/adv_item_if.sv
// Input channel carrying one neighbour ID of an adjacency list per transaction.
// Depends on adv_pkg for the default ID width.
interface adv_item_if #(
    parameter int ID_WIDTH = adv_pkg::ID_WIDTH_DEFAULT
);
    logic                valid;
    logic                ready;
    logic [ID_WIDTH-1:0] source_vertex;
    logic [ID_WIDTH-1:0] neighbor_vertex;
    logic                first_of_list;
    logic                last_of_list;

    modport source (
        output valid, source_vertex, neighbor_vertex, first_of_list, last_of_list,
        input  ready
    );

    modport sink (
        input  valid, source_vertex, neighbor_vertex, first_of_list, last_of_list,
        output ready
    );
endinterface

// File: sv/adv_byte_if.sv
// Output channel carrying one byte of the compressed stream per transaction.
// Stands alone; no package is needed.
interface adv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       run_last;
    logic       list_end;
    logic       order_error;

    modport source (
        output valid, code_byte, run_last, list_end, order_error,
        input  ready
    );

    modport sink (
        input  valid, code_byte, run_last, list_end, order_error,
        output ready
    );
endinterface

// File: sv/adv_front.sv
// Front end: accepts neighbour transactions, forms the head magnitude or the gap,
// detects descending neighbours and keeps the previous neighbour. Uses adv_pkg.
module adv_front #(
    parameter int ID_WIDTH = adv_pkg::ID_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    adv_item_if.sink             item,
    input  adv_pkg::queue_stat_t q_stat,
    output logic                 push,
    output adv_pkg::entry_ctl_t  push_ctl,
    output logic [ID_WIDTH-1:0]  push_val
);

    logic [ID_WIDTH-1:0] prev_reg;
    logic [ID_WIDTH-1:0] prev_next;
    logic                accept;
    logic                src_gt_nbr;
    logic                below;
    logic [ID_WIDTH-1:0] first_mag;
    logic [ID_WIDTH-1:0] gap;

    assign item.ready = !q_stat.full;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        src_gt_nbr = item.source_vertex > item.neighbor_vertex;
        first_mag  = src_gt_nbr ? (item.source_vertex - item.neighbor_vertex)
                                : (item.neighbor_vertex - item.source_vertex);
        below      = item.neighbor_vertex < prev_reg;
        gap        = item.neighbor_vertex - prev_reg;

        push_ctl.last = item.last_of_list;
        if (item.first_of_list)
        begin
            push_ctl.mode = src_gt_nbr ? adv_pkg::MODE_HEAD_LT : adv_pkg::MODE_HEAD_GE;
            push_val      = first_mag;
        end
        else if (below)
        begin
            push_ctl.mode = adv_pkg::MODE_ERROR;
            push_val      = '0;
        end
        else
        begin
            push_ctl.mode = adv_pkg::MODE_GAP;
            push_val      = gap;
        end

        // A repeated neighbour produces no bytes at all, so it is simply dropped.
        push = accept && (item.first_of_list || below || (gap != '0));

        prev_next = prev_reg;
        if (accept && (item.first_of_list || !below))
        begin
            prev_next = item.neighbor_vertex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
        end
    end

endmodule

// File: sv/adv_queue.sv
// Small register queue decoupling the front end from the byte serialiser.
// Uses adv_pkg for its depth and entry types.
module adv_queue #(
    parameter int ID_WIDTH = adv_pkg::ID_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  adv_pkg::entry_ctl_t  push_ctl,
    input  logic [ID_WIDTH-1:0]  push_val,
    input  logic                 pop,
    output adv_pkg::entry_ctl_t  head_ctl,
    output logic [ID_WIDTH-1:0]  head_val,
    output adv_pkg::queue_stat_t q_stat
);

    adv_pkg::entry_ctl_t        ctl_mem [adv_pkg::QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]        val_mem [adv_pkg::QUEUE_DEPTH];
    logic [adv_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [adv_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [adv_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [adv_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [adv_pkg::QPTR_W:0]   count_reg;
    logic [adv_pkg::QPTR_W:0]   count_next;
    logic                       do_push;
    logic                       do_pop;

    localparam logic [adv_pkg::QPTR_W-1:0] PTR_LAST = adv_pkg::QPTR_W'(adv_pkg::QUEUE_DEPTH - 1);
    localparam logic [adv_pkg::QPTR_W:0]   COUNT_FULL =
        (adv_pkg::QPTR_W + 1)'(adv_pkg::QUEUE_DEPTH);

    assign q_stat.full  = (count_reg == COUNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign head_ctl     = ctl_mem[rd_ptr_reg];
    assign head_val     = val_mem[rd_ptr_reg];

    always_comb
    begin
        do_push     = push && !q_stat.full;
        do_pop      = pop && !q_stat.empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctl_mem[wr_ptr_reg] <= push_ctl;
            val_mem[wr_ptr_reg] <= push_val;
        end
    end

endmodule

// File: sv/adv_back.sv
// Back end: takes coded entries from the queue and emits them one byte per
// cycle through an output register unless the output stalls. Uses adv_pkg and adv_byte_if.
module adv_back #(
    parameter int ID_WIDTH = adv_pkg::ID_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  adv_pkg::queue_stat_t q_stat,
    input  adv_pkg::entry_ctl_t  head_ctl,
    input  logic [ID_WIDTH-1:0]  head_val,
    output logic                 pop,
    adv_byte_if.source           code
);

    logic                cur_valid_reg;
    logic                cur_valid_next;
    adv_pkg::mode_t      cur_mode_reg;
    adv_pkg::mode_t      cur_mode_next;
    logic [ID_WIDTH-1:0] cur_val_reg;
    logic [ID_WIDTH-1:0] cur_val_next;
    logic                cur_last_reg;
    logic                cur_last_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          out_byte_reg;
    logic                out_run_last_reg;
    logic                out_list_end_reg;
    logic                out_error_reg;

    logic                out_free;
    logic                step;
    logic                fin;
    logic                is_error;
    logic [7:0]          byte_val;
    logic [ID_WIDTH-1:0] rem;

    assign out_free = !out_valid_reg || code.ready;
    assign step     = cur_valid_reg && out_free;

    always_comb
    begin
        is_error = 1'b0;
        case (cur_mode_reg)
            adv_pkg::MODE_HEAD_LT:
            begin
                rem      = cur_val_reg >> adv_pkg::HEAD_LOW_BITS;
                byte_val = adv_pkg::HEAD_SMALLER
                         | {2'b00, cur_val_reg[adv_pkg::HEAD_LOW_BITS-1:0]};
            end
            adv_pkg::MODE_HEAD_GE:
            begin
                rem      = cur_val_reg >> adv_pkg::HEAD_LOW_BITS;
                byte_val = adv_pkg::HEAD_GREATER
                         | {2'b00, cur_val_reg[adv_pkg::HEAD_LOW_BITS-1:0]};
            end
            adv_pkg::MODE_GAP:
            begin
                rem      = cur_val_reg >> adv_pkg::GROUP_BITS;
                byte_val = {(rem != '0), cur_val_reg[adv_pkg::GROUP_BITS-1:0]};
            end
            default:
            begin
                rem      = '0;
                byte_val = adv_pkg::ERROR_BYTE;
                is_error = 1'b1;
            end
        endcase
        fin = (rem == '0);

        pop            = !q_stat.empty && (!cur_valid_reg || (step && fin));
        cur_valid_next = cur_valid_reg;
        cur_mode_next  = cur_mode_reg;
        cur_val_next   = cur_val_reg;
        cur_last_next  = cur_last_reg;
        if (step)
        begin
            // After the head byte the remainder goes out as plain 7-bit groups.
            cur_valid_next = !fin;
            cur_mode_next  = adv_pkg::MODE_GAP;
            cur_val_next   = rem;
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_mode_next  = head_ctl.mode;
            cur_val_next   = head_val;
            cur_last_next  = head_ctl.last;
        end

        out_valid_next = out_free ? step : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_mode_reg <= cur_mode_next;
        cur_val_reg  <= cur_val_next;
        cur_last_reg <= cur_last_next;
        if (step)
        begin
            out_byte_reg     <= byte_val;
            out_run_last_reg <= fin;
            out_list_end_reg <= fin && cur_last_reg;
            out_error_reg    <= is_error;
        end
    end

    assign code.valid       = out_valid_reg;
    assign code.code_byte   = out_byte_reg;
    assign code.run_last    = out_run_last_reg;
    assign code.list_end    = out_list_end_reg;
    assign code.order_error = out_error_reg;

endmodule

// File: sv/adjacency_delta_varint_encoder.sv
// Adjacency delta varint encoder, top level. Depends on adv_pkg, both channel
// interfaces, adv_front, adv_queue and adv_back.
// With the serialiser idle, an item passes the queue, the current-entry register and the output register first.
// Each item holds the byte serialiser until its last byte is emitted, 1 to 5
// bytes at ID_WIDTH = 32; repeated neighbours are dropped at the input.
// Reset (rst_n low, asynchronous) empties the queue and output, clears previous ID.
module adjacency_delta_varint_encoder #(
    parameter int ID_WIDTH = adv_pkg::ID_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    adv_item_if.sink   item,
    adv_byte_if.source code
);

    // The front end classifies each incoming neighbour. A first neighbour is
    // coded as the magnitude of the difference to its source vertex, with a
    // direction flag in the head byte; later neighbours are coded as the gap
    // from the previous neighbour. A descending neighbour becomes a single
    // error byte, and a repeated neighbour yields nothing and is discarded.
    //
    // Classified entries wait in a two-deep queue, so the front end keeps
    // accepting transactions while the serialiser is busy with a long code.
    // The serialiser emits one byte per cycle into an output register unless the
    // output stalls; it loads the next byte in the same cycle the previous one is taken.

    adv_pkg::queue_stat_t q_stat;
    logic                 push;
    adv_pkg::entry_ctl_t  push_ctl;
    logic [ID_WIDTH-1:0]  push_val;
    logic                 pop;
    adv_pkg::entry_ctl_t  head_ctl;
    logic [ID_WIDTH-1:0]  head_val;

    adv_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .q_stat   (q_stat),
        .push     (push),
        .push_ctl (push_ctl),
        .push_val (push_val)
    );

    adv_queue #(
        .ID_WIDTH (ID_WIDTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ctl (push_ctl),
        .push_val (push_val),
        .pop      (pop),
        .head_ctl (head_ctl),
        .head_val (head_val),
        .q_stat   (q_stat)
    );

    adv_back #(
        .ID_WIDTH (ID_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head_ctl (head_ctl),
        .head_val (head_val),
        .pop      (pop),
        .code     (code)
    );

    // An error transaction is always a lone zero byte that ends its run.
    a_error_byte: assert property (@(posedge clk) disable iff (!rst_n)
        code.valid && code.order_error |-> code.code_byte == adv_pkg::ERROR_BYTE
            && code.run_last)
        else $error("error transaction carries a non-zero byte or no run end");

    // The end of a list can only be flagged on the final byte of an item.
    a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
        code.valid && code.list_end |-> code.run_last)
        else $error("list end flagged on a byte that does not end its run");

    // A byte that is not the last of its run must announce more bytes in bit 7,
    // unless it is a head byte, whose bit 7 or bit 6 carries the direction.
    a_more_flag: assert property (@(posedge clk) disable iff (!rst_n)
        code.valid && !code.run_last |-> !code.order_error
            && (code.code_byte[7] || code.code_byte[6]))
        else $error("non-final byte without a continuation or direction flag");

endmodule

// File: test/adjacency_delta_varint_encoder_tb.sv
// Self-checking testbench for the adjacency delta varint encoder: directed and random
// adjacency lists, bursty input and stalling output, with each byte checked against a predictor.
// Depends on adv_pkg, adv_item_if, adv_byte_if and adjacency_delta_varint_encoder.
module adjacency_delta_varint_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W = 32;

    // Group coding of the varint: seven payload bits, top bit marks more to come.
    localparam logic [7:0] GROUP_MASK = 8'h7f;
    localparam logic [7:0] MORE_FLAG  = 8'h80;
    localparam logic [7:0] HEAD_MASK  = 8'h3f;

    // Number of random input transactions to aim for.
    localparam int RANDOM_ITEMS = 300;

    // The long output hold-off starts once this many input transactions have been
    // accepted, which lands it in the random part while the sender keeps going.
    localparam int HOLD_TRIGGER = 60;
    localparam int HOLD_CYCLES  = 300;

    // Cycles allowed after the last expected byte for anything stray to show up.
    localparam int TAIL_CYCLES = 20;

    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [ID_W-1:0] source_vertex;
        logic [ID_W-1:0] neighbor_vertex;
        logic            first_of_list;
        logic            last_of_list;
    } neighbour_item_t;

    typedef struct {
        logic [7:0] code_byte;
        logic       run_last;
        logic       list_end;
        logic       order_error;
    } code_txn_t;

    // How the output side behaves during one window of cycles.
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_MOSTLY_OPEN,
        SINK_MOSTLY_SHUT,
        SINK_PERIODIC
    } sink_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    adv_item_if #(.ID_WIDTH(ID_W)) item_bus ();
    adv_byte_if                    code_bus ();

    adjacency_delta_varint_encoder #(
        .ID_WIDTH(ID_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_bus),
        .code  (code_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Items waiting to be offered, bytes still owed by the block, and the
    // predictor's own copy of the previous neighbour ID.
    neighbour_item_t neighbour_backlog[$];
    code_txn_t       expected_code[$];
    logic [ID_W-1:0] model_previous_id;

    int items_accepted;
    int fail_count;

    // Sender state.
    neighbour_item_t next_item;
    int              burst_left;
    int              gap_left;

    // Receiver state.
    sink_mode_t sink_mode;
    int         window_left;
    int         hold_left;
    bit         hold_done;
    int         sink_cycle;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Appends the seven-bit groups of a value, least significant first; a zero
    // value contributes no byte at all.
    task automatic append_groups(inout logic [7:0] seq[$], input logic [ID_W-1:0] value);
        logic [ID_W-1:0] rest;
        logic [7:0]      group;
        begin
            rest = value;
            while (rest != '0)
            begin
                group = {1'b0, rest[6:0]} & GROUP_MASK;
                rest  = rest >> 7;
                if (rest != '0)
                begin
                    group = group | MORE_FLAG;
                end
                seq.push_back(group);
            end
        end
    endtask

    // Works out the bytes that one accepted neighbour transaction must produce
    // and queues them as expectations. The first item of a list is coded as a
    // signed distance from its owning vertex; later items as the gap from the
    // previous neighbour. A neighbour that goes backwards yields a single error
    // byte and leaves the previous ID untouched.
    task automatic encode_neighbour(input neighbour_item_t it);
        logic [7:0]      seq[$];
        logic [ID_W-1:0] distance;
        code_txn_t       txn;
        begin
            if (it.first_of_list)
            begin
                if (it.source_vertex > it.neighbor_vertex)
                begin
                    distance = it.source_vertex - it.neighbor_vertex;
                    seq.push_back(adv_pkg::HEAD_SMALLER | (distance[7:0] & HEAD_MASK));
                end
                else
                begin
                    distance = it.neighbor_vertex - it.source_vertex;
                    seq.push_back(adv_pkg::HEAD_GREATER | (distance[7:0] & HEAD_MASK));
                end
                append_groups(seq, distance >> 6);
                model_previous_id = it.neighbor_vertex;
            end
            else if (it.neighbor_vertex < model_previous_id)
            begin
                txn.code_byte   = adv_pkg::ERROR_BYTE;
                txn.run_last    = 1'b1;
                txn.list_end    = it.last_of_list;
                txn.order_error = 1'b1;
                expected_code.push_back(txn);
            end
            else
            begin
                append_groups(seq, it.neighbor_vertex - model_previous_id);
                model_previous_id = it.neighbor_vertex;
            end

            // The error case leaves seq empty, so this loop adds nothing then.
            foreach (seq[k])
            begin
                txn.code_byte   = seq[k];
                txn.run_last    = (k == seq.size() - 1);
                txn.list_end    = txn.run_last && it.last_of_list;
                txn.order_error = 1'b0;
                expected_code.push_back(txn);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: offers the backlog in bursts of random length with random
    // gaps between them. A transaction is held until it is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_bus.valid           <= 1'b0;
            item_bus.source_vertex   <= '0;
            item_bus.neighbor_vertex <= '0;
            item_bus.first_of_list   <= 1'b0;
            item_bus.last_of_list    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!item_bus.valid || item_bus.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                item_bus.valid <= 1'b0;
            end
            else if (neighbour_backlog.size() != 0)
            begin
                next_item = neighbour_backlog.pop_front();
                item_bus.valid           <= 1'b1;
                item_bus.source_vertex   <= next_item.source_vertex;
                item_bus.neighbor_vertex <= next_item.neighbor_vertex;
                item_bus.first_of_list   <= next_item.first_of_list;
                item_bus.last_of_list    <= next_item.last_of_list;
                if (burst_left > 0)
                begin
                    burst_left = burst_left - 1;
                end
                else
                begin
                    // A third of the bursts run straight into the next one.
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
            begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: changes its stall pattern after each window of random length, and once
    // holds off for a long stretch so that the block fills and stalls its input.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_bus.ready <= 1'b0;
            sink_mode   = SINK_OPEN;
            window_left = 0;
            hold_left   = 0;
            hold_done   = 1'b0;
            sink_cycle  = 0;
        end
        else
        begin
            sink_cycle = sink_cycle + 1;
            if (!hold_done && items_accepted >= HOLD_TRIGGER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                code_bus.ready <= 1'b0;
            end
            else
            begin
                if (window_left == 0)
                begin
                    sink_mode   = sink_mode_t'($urandom_range(0, 3));
                    window_left = $urandom_range(16, 80);
                end
                window_left = window_left - 1;
                case (sink_mode)
                    SINK_OPEN:        code_bus.ready <= 1'b1;
                    SINK_MOSTLY_OPEN: code_bus.ready <= ($urandom_range(0, 3) != 0);
                    SINK_MOSTLY_SHUT: code_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:          code_bus.ready <= (sink_cycle % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted input transaction and checks every
    // accepted output transaction against the oldest expectation. Input is
    // handled first so that both sides see one consistent queue in a cycle.
    // ------------------------------------------------------------------
    task automatic note_failure(input string what, input code_txn_t want, input code_txn_t got);
        begin
            fail_count = fail_count + 1;
            if (fail_count <= MAX_REPORTS)
            begin
                $display("%0t: %s: expected byte %02h last %0b end %0b err %0b, ",
                         $realtime, what,
                         want.code_byte, want.run_last, want.list_end, want.order_error,
                         "got byte %02h last %0b end %0b err %0b",
                         got.code_byte, got.run_last, got.list_end, got.order_error);
            end
        end
    endtask

    neighbour_item_t seen_item;
    code_txn_t       seen_code;
    code_txn_t       owed_code;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                seen_item.source_vertex   = item_bus.source_vertex;
                seen_item.neighbor_vertex = item_bus.neighbor_vertex;
                seen_item.first_of_list   = item_bus.first_of_list;
                seen_item.last_of_list    = item_bus.last_of_list;
                encode_neighbour(seen_item);
                items_accepted <= items_accepted + 1;
            end

            if (code_bus.valid && code_bus.ready)
            begin
                seen_code.code_byte   = code_bus.code_byte;
                seen_code.run_last    = code_bus.run_last;
                seen_code.list_end    = code_bus.list_end;
                seen_code.order_error = code_bus.order_error;
                if (expected_code.size() == 0)
                begin
                    owed_code = '{default: '0};
                    note_failure("byte with nothing expected", owed_code, seen_code);
                end
                else
                begin
                    owed_code = expected_code.pop_front();
                    if (seen_code.code_byte !== owed_code.code_byte
                        || seen_code.run_last !== owed_code.run_last
                        || seen_code.list_end !== owed_code.list_end
                        || seen_code.order_error !== owed_code.order_error)
                    begin
                        note_failure("byte mismatch", owed_code, seen_code);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [ID_W-1:0] src, input logic [ID_W-1:0] nbr,
                              input logic first, input logic last);
        neighbour_item_t it;
        begin
            it.source_vertex   = src;
            it.neighbor_vertex = nbr;
            it.first_of_list   = first;
            it.last_of_list    = last;
            neighbour_backlog.push_back(it);
        end
    endtask

    // Gap sizes spread over every varint length, with zero gaps now and then.
    function automatic logic [ID_W-1:0] pick_gap();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:          pick_gap = '0;
                1, 2, 3, 4: pick_gap = $urandom_range(1, 127);
                5, 6:       pick_gap = $urandom_range(128, 16383);
                7, 8:       pick_gap = $urandom_range(16384, 2097151);
                default:    pick_gap = $urandom >> $urandom_range(0, 6);
            endcase
        end
    endfunction

    // Queues one adjacency list of random content. Most lists are well formed;
    // a few carry a backwards neighbour or lose their closing mark.
    task automatic queue_random_list(input int count, inout int queued);
        logic [ID_W-1:0] src;
        logic [ID_W-1:0] prev;
        logic [ID_W-1:0] nbr;
        logic [ID_W:0]   sum;
        logic            last;
        bit              drop_end;
        int              pick;
        begin
            pick = $urandom_range(0, 2);
            src  = (pick == 0) ? $urandom : $urandom_range(0, 4000);
            pick = $urandom_range(0, 2);
            case (pick)
                0:       prev = src + $urandom_range(0, 400) - 200;
                1:       prev = $urandom;
                default: prev = $urandom_range(0, 5000);
            endcase
            drop_end = ($urandom_range(0, 14) == 0);

            for (int i = 0; i < count; i++)
            begin
                last = (i == count - 1) && !drop_end;
                if (i == 0)
                begin
                    queue_item(src, prev, 1'b1, last);
                end
                else if ($urandom_range(0, 9) == 0 && prev != '0)
                begin
                    // Backwards step: the encoder reports it and keeps its old ID.
                    nbr = prev - $urandom_range(1, (prev > 1000) ? 1000 : prev);
                    queue_item($urandom, nbr, 1'b0, last);
                end
                else
                begin
                    sum  = {1'b0, prev} + {1'b0, pick_gap()};
                    prev = sum[ID_W] ? '1 : sum[ID_W-1:0];
                    queue_item($urandom, prev, 1'b0, last);
                end
                queued = queued + 1;
            end
        end
    endtask

    // Waits until the sender has nothing left and every owed byte has arrived.
    task automatic wait_drained();
        begin
            do
                @(negedge clk);
            while (neighbour_backlog.size() != 0 || item_bus.valid || expected_code.size() != 0);
        end
    endtask

    initial
    begin
        int queued;

        // All inputs start at known values; the clocked blocks take over at reset.
        rst_n                    = 1'b0;
        item_bus.valid           = 1'b0;
        item_bus.source_vertex   = '0;
        item_bus.neighbor_vertex = '0;
        item_bus.first_of_list   = 1'b0;
        item_bus.last_of_list    = 1'b0;
        code_bus.ready           = 1'b0;
        model_previous_id        = '0;
        items_accepted           = 0;
        fail_count               = 0;
        queued                   = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. A continuation arriving straight after reset is coded
        // against an ID of zero; then a repeated ID with an end mark, which must
        // produce nothing, and two backwards steps, the second closing a list.
        queue_item(32'd0, 32'd5, 1'b0, 1'b0);
        queue_item(32'd0, 32'd5, 1'b0, 1'b1);
        queue_item(32'd0, 32'd3, 1'b0, 1'b0);
        queue_item(32'd0, 32'd2, 1'b0, 1'b1);
        // Neighbour equal to its source takes the greater-or-equal head.
        queue_item(32'd0, 32'd0, 1'b1, 1'b0);
        // A distance of 64 in both directions spills exactly one group.
        queue_item(32'd100, 32'd36, 1'b1, 1'b0);
        queue_item(32'd5, 32'd69, 1'b1, 1'b0);
        // Largest distance upwards, then a repeat of that ID closing the list.
        queue_item(32'd0, 32'hffff_ffff, 1'b1, 1'b0);
        queue_item(32'd0, 32'hffff_ffff, 1'b0, 1'b1);
        // Single-element list with the largest downward distance.
        queue_item(32'hffff_ffff, 32'd0, 1'b1, 1'b1);
        // Largest possible gap, from zero to the top ID.
        queue_item(32'd0, 32'hffff_ffff, 1'b0, 1'b1);
        // Distance 63 fits the head byte alone, both directions.
        queue_item(32'd200, 32'd263, 1'b1, 1'b0);
        queue_item(32'd200, 32'd137, 1'b1, 1'b0);
        // Gaps at every group boundary: 127, 128, 16383, 16384, 2^21, 2^28.
        queue_item(32'd0, 32'd264, 1'b0, 1'b0);
        queue_item(32'd0, 32'd392, 1'b0, 1'b0);
        queue_item(32'd0, 32'd16775, 1'b0, 1'b0);
        queue_item(32'd0, 32'd33159, 1'b0, 1'b0);
        queue_item(32'd0, 32'd2130311, 1'b0, 1'b0);
        queue_item(32'd0, 32'd270565767, 1'b0, 1'b1);
        // Alternating bit patterns on both IDs.
        queue_item(32'haaaa_aaaa, 32'h5555_5555, 1'b1, 1'b0);
        queue_item(32'h5555_5555, 32'haaaa_aaaa, 1'b1, 1'b1);

        // The sender pauses here until every owed byte has come back.
        wait_drained();

        // Random part: mostly well-formed lists, with stray continuations as noise.
        while (queued < RANDOM_ITEMS)
        begin
            @(negedge clk);
            if ($urandom_range(0, 19) == 0)
            begin
                queue_item($urandom, $urandom, 1'b0, 1'($urandom_range(0, 1)));
                queued = queued + 1;
            end
            else
            begin
                queue_random_list($urandom_range(1, 8), queued);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (expected_code.size() != 0)
        begin
            fail_count = fail_count + 1;
            $display("%0t: %0d expected bytes never arrived", $realtime, expected_code.size());
        end

        if (fail_count == 0)
        begin
            $display("adjacency_delta_varint_encoder_tb: PASS");
        end
        else
        begin
            $display("adjacency_delta_varint_encoder_tb: FAIL");
        end
        $finish;
    end

    // Safety net: well beyond the slowest correct run.
    initial
    begin
        #1_000_000;
        $display("adjacency_delta_varint_encoder_tb: FAIL");
        $finish;
    end

endmodule
